// ----- sv/mbvd_pkg.sv -----
// ----------------------------------------------------------------------------
// mbvd_pkg
// shared types, constants and the microcode table of the back-emf drive block
// ----------------------------------------------------------------------------
package mbvd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ANGLE_OFFSET = 3'd0;
  localparam logic [2:0] REG_DIRECTION    = 3'd1;
  localparam logic [2:0] REG_MAX_VOLTAGE  = 3'd2;
  localparam logic [2:0] REG_TORQUE_GAIN  = 3'd3;
  localparam logic [2:0] REG_COEF_CUBIC   = 3'd4;
  localparam logic [2:0] REG_COEF_SQUARE  = 3'd5;
  localparam logic [2:0] REG_COEF_LINEAR  = 3'd6;

  // reset values of the registers
  localparam logic [14:0] MAX_VOLTAGE_RST = 15'd7000;
  localparam logic [15:0] TORQUE_GAIN_RST = 16'd5120;
  localparam logic [31:0] COEF_CUBIC_RST  = 32'd33554;
  localparam logic [31:0] COEF_SQUARE_RST = 32'hFFCC_CCCD;  // -3355443
  localparam logic [31:0] COEF_LINEAR_RST = 32'd874079846;

  // reciprocal of ten, exact for any 16-bit magnitude after >> 19
  localparam logic [15:0] K_DIV10  = 16'd52429;
  // 2*pi/60 in q16
  localparam logic [12:0] K_SPEED  = 13'd6863;
  // horner saturation bound, 2^37
  localparam logic signed [48:0] HORNER_LIM = 49'sd137438953472;

  // multiplier operand selects
  localparam logic [2:0] MUL_NONE   = 3'd0;
  localparam logic [2:0] MUL_DIV10  = 3'd1;
  localparam logic [2:0] MUL_SCALE  = 3'd2;
  localparam logic [2:0] MUL_TORQUE = 3'd3;
  localparam logic [2:0] MUL_LO     = 3'd4;
  localparam logic [2:0] MUL_HI     = 3'd5;

  // accumulator operations
  localparam logic [1:0] ACC_HOLD   = 2'd0;
  localparam logic [1:0] ACC_LOAD   = 2'd1;
  localparam logic [1:0] ACC_ADD_HI = 2'd2;

  // program addresses
  localparam logic [3:0] STEP_FB_DIV   = 4'd0;
  localparam logic [3:0] STEP_FB_SCALE = 4'd1;
  localparam logic [3:0] STEP_FB_EMIT  = 4'd2;
  localparam logic [3:0] STEP_CM_TORQ  = 4'd3;
  localparam logic [3:0] STEP_CM_LATCH = 4'd4;
  localparam logic [3:0] STEP_CM_LO    = 4'd5;
  localparam logic [3:0] STEP_CM_HI    = 4'd6;
  localparam logic [3:0] STEP_CM_SUM   = 4'd7;
  localparam logic [3:0] STEP_CM_NEXT  = 4'd8;
  localparam logic [3:0] STEP_CM_EMIT  = 4'd9;

  typedef struct packed {
    logic [31:0] angle_offset;
    logic        dir_neg;
    logic [14:0] max_mv;
    logic [15:0] gain;
    logic [31:0] coef_cubic;
    logic [31:0] coef_square;
    logic [31:0] coef_linear;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic       load_cubic;
    logic       latch_tq;
    logic       loop_back;   // horner update and jump while terms remain
    logic       emit_fb;
    logic       emit_cmd;
    logic [3:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [3:0] step);
    ucode_t w;
    w = '0;
    case (step)
      STEP_FB_DIV:   w.mul_sel = MUL_DIV10;
      STEP_FB_SCALE: w.mul_sel = MUL_SCALE;
      STEP_FB_EMIT:  w.emit_fb = 1'b1;
      STEP_CM_TORQ: begin
        w.mul_sel    = MUL_TORQUE;
        w.load_cubic = 1'b1;
      end
      STEP_CM_LATCH: w.latch_tq = 1'b1;
      STEP_CM_LO:    w.mul_sel  = MUL_LO;
      STEP_CM_HI: begin
        w.mul_sel = MUL_HI;
        w.acc_op  = ACC_LOAD;
      end
      STEP_CM_SUM:   w.acc_op = ACC_ADD_HI;
      STEP_CM_NEXT: begin
        w.loop_back = 1'b1;
        w.target    = STEP_CM_LO;
      end
      STEP_CM_EMIT:  w.emit_cmd = 1'b1;
      default:       w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- sv/mbvd_seq.sv -----
// ----------------------------------------------------------------------------
// mbvd_seq
// step counter and microcode fetch, with conditional loop jump
// ----------------------------------------------------------------------------
module mbvd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                start_cmd,
  input  logic                more,
  input  logic                stall,
  output logic                busy,
  output mbvd_pkg::ucode_t    ctrl
);

  logic [3:0]       step;
  mbvd_pkg::ucode_t word;
  logic             emit_any;

  always_comb begin
    word     = mbvd_pkg::ucode_rom(step);
    emit_any = word.emit_fb | word.emit_cmd;
    ctrl     = busy ? word : '0;
    // hold the emit step while the result register is full
    if (stall) begin
      ctrl.emit_fb  = 1'b0;
      ctrl.emit_cmd = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= mbvd_pkg::STEP_FB_DIV;
    end else if (start) begin
      busy <= 1'b1;
      step <= start_cmd ? mbvd_pkg::STEP_CM_TORQ : mbvd_pkg::STEP_FB_DIV;
    end else if (busy) begin
      if (emit_any) begin
        if (!stall) busy <= 1'b0;
      end else if (word.loop_back && more) begin
        step <= word.target;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

endmodule

// ----- sv/mbvd_dp.sv -----
// ----------------------------------------------------------------------------
// mbvd_dp
// shared 19x25 multiplier, accumulator, horner register and result logic
// ----------------------------------------------------------------------------
module mbvd_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         raw_angle,
  input  logic [15:0]         raw_speed,
  input  logic [15:0]         torque_milli,
  input  mbvd_pkg::cfg_t      cfg,
  input  mbvd_pkg::ucode_t    ctrl,
  output logic                more,
  output logic [32:0]         angle_val,
  output logic [25:0]         speed_val,
  output logic [15:0]         volt_val
);

  // latched item
  logic [31:0] angle_q;
  logic [15:0] speed_q;
  logic [15:0] torque_q;

  logic [25:0] speed_now;
  logic [24:0] smag;
  logic [16:0] speed_mag;
  logic [16:0] torque_mag;
  logic [32:0] cubic_mag;

  logic [18:0] mul_a;
  logic [24:0] mul_b;
  logic [43:0] prod;
  logic [62:0] acc;

  logic [37:0] a_mag;
  logic        a_neg;
  logic [1:0]  term;

  logic [22:0] tq_mag;
  logic        tq_neg;

  logic [46:0]        hm_mag;
  logic signed [48:0] hm;
  logic signed [48:0] hx;
  logic signed [48:0] hsat;
  logic [31:0]        coef;

  logic [22:0]        emf_mag;
  logic               emf_neg;
  logic signed [25:0] v_sum;
  logic signed [25:0] v_max;
  logic signed [25:0] v_sat;
  logic signed [32:0] diff;

  always_ff @(posedge clk) begin
    if (start) begin
      angle_q  <= raw_angle;
      speed_q  <= raw_speed;
      torque_q <= torque_milli;
    end
  end

  assign speed_mag  = speed_q[15] ? (17'd0 - {speed_q[15], speed_q}) : {1'b0, speed_q};
  assign torque_mag = torque_q[15] ? (17'd0 - {torque_q[15], torque_q})
                                   : {1'b0, torque_q};
  assign cubic_mag  = cfg.coef_cubic[31] ? (33'd0 - {cfg.coef_cubic[31], cfg.coef_cubic})
                                         : {1'b0, cfg.coef_cubic};
  assign smag       = speed_now[25] ? 25'(26'd0 - speed_now) : speed_now[24:0];

  always_comb begin
    case (ctrl.mul_sel)
      mbvd_pkg::MUL_DIV10: begin
        mul_a = 19'(speed_mag);
        mul_b = 25'(mbvd_pkg::K_DIV10);
      end
      mbvd_pkg::MUL_SCALE: begin
        mul_a = 19'(prod[32:19]);
        mul_b = 25'(mbvd_pkg::K_SPEED);
      end
      mbvd_pkg::MUL_TORQUE: begin
        mul_a = 19'(torque_mag);
        mul_b = 25'(cfg.gain);
      end
      mbvd_pkg::MUL_LO: begin
        mul_a = a_mag[18:0];
        mul_b = smag;
      end
      mbvd_pkg::MUL_HI: begin
        mul_a = a_mag[37:19];
        mul_b = smag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product holds on steps without a multiply, so a stalled emit keeps it
  always_ff @(posedge clk) begin
    if (ctrl.mul_sel != mbvd_pkg::MUL_NONE) begin
      prod <= 44'(mul_a) * 44'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      mbvd_pkg::ACC_LOAD:   acc <= 63'(prod);
      mbvd_pkg::ACC_ADD_HI: acc <= acc + {prod, 19'b0};
      default:              acc <= acc;
    endcase
  end

  // horner step: a = sat(tshift(a*s, 16) + coef)
  assign hm_mag = acc[62:16];
  assign hm     = a_neg ? -$signed({2'b0, hm_mag}) : $signed({2'b0, hm_mag});
  assign coef   = (term == 2'd0) ? cfg.coef_square : cfg.coef_linear;
  assign hx     = hm + $signed({{17{coef[31]}}, coef});

  always_comb begin
    if (hx > mbvd_pkg::HORNER_LIM)       hsat = mbvd_pkg::HORNER_LIM;
    else if (hx < -mbvd_pkg::HORNER_LIM) hsat = -mbvd_pkg::HORNER_LIM;
    else                                 hsat = hx;
  end

  assign more = (term != 2'd2);

  always_ff @(posedge clk) begin
    if (ctrl.load_cubic) begin
      a_mag <= 38'(cubic_mag);
      a_neg <= cfg.coef_cubic[31];
      term  <= 2'd0;
    end else if (ctrl.loop_back && more) begin
      a_mag <= hsat[48] ? 38'(-hsat) : 38'(hsat);
      a_neg <= hsat[48];
      term  <= term + 2'd1;
    end
    if (ctrl.latch_tq) begin
      tq_mag <= prod[30:8];
      tq_neg <= torque_q[15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_now <= '0;
    end else if (ctrl.emit_fb) begin
      speed_now <= speed_val;
    end
  end

  // feedback results
  assign diff      = $signed({angle_q[31], angle_q}) -
                     $signed({cfg.angle_offset[31], cfg.angle_offset});
  assign angle_val = cfg.dir_neg ? 33'(-diff) : 33'(diff);
  assign speed_val = (speed_q[15] ^ cfg.dir_neg) ? (26'd0 - {1'b0, prod[24:0]})
                                                 : {1'b0, prod[24:0]};

  // command result: torque term plus signed back-emf, clamped, then direction-corrected
  assign emf_mag = acc[62:40];
  assign emf_neg = a_neg ^ speed_now[25];
  assign v_max   = $signed({11'b0, cfg.max_mv});
  assign v_sum   = (tq_neg ? -$signed({3'b0, tq_mag}) : $signed({3'b0, tq_mag})) +
                   (emf_neg ? -$signed({3'b0, emf_mag}) : $signed({3'b0, emf_mag}));

  always_comb begin
    if (v_sum > v_max)       v_sat = v_max;
    else if (v_sum < -v_max) v_sat = -v_max;
    else                     v_sat = v_sum;
  end

  assign volt_val = cfg.dir_neg ? 16'(-v_sat) : 16'(v_sat);

endmodule

// ----- sv/motor_backemf_voltage_drive_top.sv -----
// ----------------------------------------------------------------------------
// motor_backemf_voltage_drive_top
// back-emf feedforward drive voltage from torque commands and speed feedback
// ----------------------------------------------------------------------------
// usage:
//   slave channel s_*: one beat is one item; s_tuser selects feedback (0) or
//   torque command (1). feedback beats return the direction-corrected angle
//   and speed and keep the speed for later commands; command beats return
//   the clamped drive voltage in millivolts.
//   master channel m_*: one result beat per item, in item order.
//   config port: cfg_we with cfg_index/cfg_data writes one register; the user writes
//   only while the block is idle (the block does not enforce it); indexes past the register list are dropped.
// sequencing:
//   a microcoded sequencer steps one shared 19x25 multiplier. a feedback
//   item runs a divide, a scale and an emit step; a command runs a torque
//   step, a latch step, the horner passes and an emit step (the cubic
//   back-emf polynomial takes three 4-step horner passes, each product built
//   from two partial products). s_tready is low while an item is in work.
// reset: rst is synchronous; registers return to their defaults, the kept
//   speed clears to zero and both channels come up empty.
// stall: the result sits in an output register; a new item is accepted
//   while it waits, and the sequencer holds its emit step until m_tready.
// ----------------------------------------------------------------------------
module motor_backemf_voltage_drive_top (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // raw_angle[31:0], raw_speed[47:32], torque_milli[63:48]
  input  logic        s_tuser,   // kind
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // angle_out[32:0], speed_out[58:33], voltage_mv[74:59], zeros
  // register writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  mbvd_pkg::cfg_t   cfg;
  mbvd_pkg::ucode_t ctrl;

  logic        busy;
  logic        start;
  logic        stall;
  logic        more;
  logic [32:0] angle_val;
  logic [25:0] speed_val;
  logic [15:0] volt_val;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_offset <= '0;
      cfg.dir_neg      <= 1'b0;
      cfg.max_mv       <= mbvd_pkg::MAX_VOLTAGE_RST;
      cfg.gain         <= mbvd_pkg::TORQUE_GAIN_RST;
      cfg.coef_cubic   <= mbvd_pkg::COEF_CUBIC_RST;
      cfg.coef_square  <= mbvd_pkg::COEF_SQUARE_RST;
      cfg.coef_linear  <= mbvd_pkg::COEF_LINEAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mbvd_pkg::REG_ANGLE_OFFSET: cfg.angle_offset <= cfg_data;
        mbvd_pkg::REG_DIRECTION:    cfg.dir_neg      <= cfg_data[0];
        mbvd_pkg::REG_MAX_VOLTAGE:  cfg.max_mv       <= cfg_data[14:0];
        mbvd_pkg::REG_TORQUE_GAIN:  cfg.gain         <= cfg_data[15:0];
        mbvd_pkg::REG_COEF_CUBIC:   cfg.coef_cubic   <= cfg_data;
        mbvd_pkg::REG_COEF_SQUARE:  cfg.coef_square  <= cfg_data;
        mbvd_pkg::REG_COEF_LINEAR:  cfg.coef_linear  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side: take a beat whenever the sequencer is free and out of reset
  assign s_tready = ~busy & ~rst;
  assign start    = s_tvalid & s_tready;
  // output register still holds an untaken beat
  assign stall    = m_tvalid & ~m_tready;

  mbvd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_cmd (s_tuser),
    .more      (more),
    .stall     (stall),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  mbvd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .raw_angle    (s_tdata[31:0]),
    .raw_speed    (s_tdata[47:32]),
    .torque_milli (s_tdata[63:48]),
    .cfg          (cfg),
    .ctrl         (ctrl),
    .more         (more),
    .angle_val    (angle_val),
    .speed_val    (speed_val),
    .volt_val     (volt_val)
  );

  // result register; fields of the other item kind read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit_fb || ctrl.emit_cmd) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_fb) begin
      m_tdata <= {5'b0, 16'd0, speed_val, angle_val};
    end else if (ctrl.emit_cmd) begin
      m_tdata <= {5'b0, volt_val, 26'd0, 33'd0};
    end
  end

  // an emit never overwrites a beat that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit_fb || ctrl.emit_cmd) |-> !stall)
    else $error("result emitted into a full output register");

  // an accepted item always starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("sequencer idle after an accepted item");

  // the drive voltage never leaves the clamp window
  a_volt_clamp: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit_cmd |->
      ($signed(volt_val) <= $signed({1'b0, cfg.max_mv})) &&
      ($signed(volt_val) >= -$signed({1'b0, cfg.max_mv})))
    else $error("drive voltage outside clamp");

endmodule

// ----- bench/motor_backemf_voltage_drive_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_backemf_voltage_drive_top_tb
// checks feedback and torque command beats against a cycle-free drive model
// ----------------------------------------------------------------------------
// items go in through a queue that the driver drains. Every accepted item is
// run through a behavioral model of the angle, speed and back-emf voltage
// math, and the result lands in a queue of predicted results. The monitor
// compares each result beat, field by field, with the oldest prediction.
// Register settings change only between phases while the block is idle.
// ----------------------------------------------------------------------------
module motor_backemf_voltage_drive_top_tb;

  localparam logic KIND_FEEDBACK = 1'b0;
  localparam logic KIND_COMMAND  = 1'b1;
  // one past the register list, writes there must be dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // 2*pi/60 in q16.16, and the horner clip level in q24
  localparam longint SPEED_Q16    = 64'sd6863;
  localparam longint HORNER_BOUND = 64'sd137438953472;
  localparam int     SETTLE_CYCLES = 24;

  typedef struct {
    logic        kind;
    logic [31:0] raw_angle;
    logic [15:0] raw_speed;
    logic [15:0] torque;
  } drive_item_t;

  typedef struct {
    logic [32:0] angle;
    logic [25:0] speed;
    logic [15:0] volt;
  } drive_result_t;

  // dut ports, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // raw_angle[31:0], raw_speed[47:32], torque_milli[63:48]
  logic        s_tuser = 1'b0; // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // angle_out[32:0], speed_out[58:33], voltage_mv[74:59], zeros
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  motor_backemf_voltage_drive_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // items waiting to be offered, and results still owed by the block
  drive_item_t   pending_items[$];
  drive_result_t expected_results[$];

  int  mismatches = 0;
  int  beats_in = 0;
  bit  item_taken = 1'b0;  // input beat seen at the last rising edge
  bit  no_gaps = 1'b0;     // quiet stretch, neither side idles
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;

  // model copy of the registers and the kept speed
  longint offset_q, max_mv_q, gain_q, coef3_q, coef2_q, coef1_q, speed_kept;
  bit     dir_neg_q;

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  task automatic reset_model();
    offset_q   = 0;
    dir_neg_q  = 1'b0;
    max_mv_q   = longint'(mbvd_pkg::MAX_VOLTAGE_RST);
    gain_q     = longint'(mbvd_pkg::TORQUE_GAIN_RST);
    coef3_q    = longint'($signed(mbvd_pkg::COEF_CUBIC_RST));
    coef2_q    = longint'($signed(mbvd_pkg::COEF_SQUARE_RST));
    coef1_q    = longint'($signed(mbvd_pkg::COEF_LINEAR_RST));
    speed_kept = 0;
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      mbvd_pkg::REG_ANGLE_OFFSET: offset_q  = longint'($signed(val));
      mbvd_pkg::REG_DIRECTION:    dir_neg_q = val[0];
      mbvd_pkg::REG_MAX_VOLTAGE:  max_mv_q  = longint'(val[14:0]);
      mbvd_pkg::REG_TORQUE_GAIN:  gain_q    = longint'(val[15:0]);
      mbvd_pkg::REG_COEF_CUBIC:   coef3_q   = longint'($signed(val));
      mbvd_pkg::REG_COEF_SQUARE:  coef2_q   = longint'($signed(val));
      mbvd_pkg::REG_COEF_LINEAR:  coef1_q   = longint'($signed(val));
      default: ;
    endcase
  endtask

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // cubic back-emf in mv for a non-negative q16.16 speed, horner in q24;
  // signed division truncates toward zero like the hardware shifts
  function automatic longint emf_mv(input longint s);
    longint a;
    a = coef3_q;
    a = clip(a * s / 65536 + coef2_q, HORNER_BOUND);
    a = clip(a * s / 65536 + coef1_q, HORNER_BOUND);
    a = a * s / 65536;
    return a / 64'sd16777216;
  endfunction

  function automatic drive_result_t predict_drive(input drive_item_t it);
    drive_result_t r;
    longint dir, a, s, v;
    dir = dir_neg_q ? -64'sd1 : 64'sd1;
    r.angle = '0;
    r.speed = '0;
    r.volt  = '0;
    if (it.kind == KIND_FEEDBACK) begin
      a = (longint'($signed(it.raw_angle)) - offset_q) * dir;
      s = (longint'($signed(it.raw_speed)) / 10) * SPEED_Q16 * dir;
      speed_kept = s;
      r.angle = a[32:0];
      r.speed = s[25:0];
    end else begin
      v = longint'($signed(it.torque)) * gain_q / 256;
      if (speed_kept >= 0) v = v + emf_mv(speed_kept);
      else v = v - emf_mv(-speed_kept);
      v = clip(v, max_mv_q) * dir;
      r.volt = v[15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // rising edge: register writes, accepted items and result beats
  always @(posedge clk) begin
    drive_item_t   it;
    drive_result_t want;
    item_taken = !rst && s_tvalid && s_tready;
    if (rst) begin
      reset_model();
    end else if (cfg_we) begin
      apply_reg(cfg_index, cfg_data);
    end
    if (item_taken) begin
      it = pending_items.pop_front();
      expected_results.push_back(predict_drive(it));
      beats_in++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[32:0] !== want.angle)
          report_mismatch("angle_out", longint'($signed(m_tdata[32:0])),
                          longint'($signed(want.angle)));
        if (m_tdata[58:33] !== want.speed)
          report_mismatch("speed_out", longint'($signed(m_tdata[58:33])),
                          longint'($signed(want.speed)));
        if (m_tdata[74:59] !== want.volt)
          report_mismatch("voltage_mv", longint'($signed(m_tdata[74:59])),
                          longint'($signed(want.volt)));
        if (m_tdata[79:75] !== 5'd0)
          report_mismatch("padding", longint'(m_tdata[79:75]), 0);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // item driver: offers the head of the queue, skipping an offer with a 6 percent chance
  always @(negedge clk) begin
    bit gap;
    drive_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      gap = !no_gaps && ($urandom_range(0, 99) < 6);
      if (pending_items.size() != 0 && !gap) begin
        it = pending_items[0];
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.torque, it.raw_speed, it.raw_angle};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus one long hold-off mid run so the
  // output register fills and the input side backs up
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!long_hold_done && beats_in >= 700) begin
        hold_left = 250;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic drive_item_t fb_item(input logic [31:0] ang, input logic [15:0] spd);
    drive_item_t it;
    it.kind      = KIND_FEEDBACK;
    it.raw_angle = ang;
    it.raw_speed = spd;
    it.torque    = 16'($urandom);  // ignored on feedback
    return it;
  endfunction

  function automatic drive_item_t cmd_item(input logic [15:0] tq);
    drive_item_t it;
    it.kind      = KIND_COMMAND;
    it.raw_angle = $urandom;  // ignored on commands
    it.raw_speed = 16'($urandom);
    it.torque    = tq;
    return it;
  endfunction

  // 16-bit value biased toward small magnitudes and the range ends
  function automatic logic [15:0] rand_word16();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 400) - 200);
      2: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      default: return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 32767))
                                                  : -16'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(input logic [31:0] base);
    case ($urandom_range(0, 3))
      0: return base;
      1: return $urandom;
      2: return 32'($signed(base) / $signed(32'($urandom_range(1, 8))));
      default: return -base;
    endcase
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) != 0) pending_items.push_back(cmd_item(rand_word16()));
      else pending_items.push_back(fb_item($urandom, rand_word16()));
    end
  endtask

  // range ends, speeds that truncate to zero, both speed signs before commands
  task automatic push_directed();
    pending_items.push_back(fb_item(32'd0, 16'd0));
    pending_items.push_back(cmd_item(16'd0));
    pending_items.push_back(cmd_item(16'h7FFF));
    pending_items.push_back(cmd_item(16'h8000));
    pending_items.push_back(fb_item(32'h7FFF_FFFF, 16'h7FFF));
    pending_items.push_back(cmd_item(16'd1));
    pending_items.push_back(cmd_item(-16'd1));
    pending_items.push_back(fb_item(32'h8000_0000, 16'h8000));
    pending_items.push_back(cmd_item(16'h7FFF));
    pending_items.push_back(cmd_item(16'h8000));
    pending_items.push_back(fb_item(32'd123, 16'd9));
    pending_items.push_back(cmd_item(16'd100));
    pending_items.push_back(fb_item(-32'd5, -16'd19));
    pending_items.push_back(cmd_item(-16'd100));
    pending_items.push_back(fb_item(32'd0, 16'd15000));
    pending_items.push_back(cmd_item(16'd2000));
  endtask

  // wait until every result is back, then let the sequencer settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic write_all(input logic [31:0] offs, input logic dneg, input logic [14:0] vmax,
                           input logic [15:0] gain, input logic [31:0] c3,
                           input logic [31:0] c2, input logic [31:0] c1);
    write_reg(mbvd_pkg::REG_ANGLE_OFFSET, offs);
    write_reg(mbvd_pkg::REG_DIRECTION, {31'($urandom), dneg});  // upper bits must be ignored
    write_reg(mbvd_pkg::REG_MAX_VOLTAGE, {17'($urandom), vmax});
    write_reg(mbvd_pkg::REG_TORQUE_GAIN, {16'($urandom), gain});
    write_reg(mbvd_pkg::REG_COEF_CUBIC, c3);
    write_reg(mbvd_pkg::REG_COEF_SQUARE, c2);
    write_reg(mbvd_pkg::REG_COEF_LINEAR, c1);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings
    push_directed();
    push_random(150);
    wait_idle();

    // upper extremes, negative direction, horner clipping on the high side;
    // a write past the register list rides along and must change nothing
    write_all(32'h8000_0000, 1'b1, 15'h7FFF, 16'hFFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    write_reg(REG_UNUSED, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    push_directed();
    push_random(100);
    wait_idle();

    // lower extremes: zero clamp, zero gain, horner clipping on the low side
    write_all(32'h7FFF_FFFF, 1'b0, 15'd0, 16'd0,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_directed();
    push_random(100);
    wait_idle();

    // default coefficients with the other direction, no idling at all
    write_all($urandom, 1'b1, mbvd_pkg::MAX_VOLTAGE_RST, mbvd_pkg::TORQUE_GAIN_RST,
              mbvd_pkg::COEF_CUBIC_RST, mbvd_pkg::COEF_SQUARE_RST,
              mbvd_pkg::COEF_LINEAR_RST);
    no_gaps = 1'b1;
    push_random(200);
    wait_idle();
    no_gaps = 1'b0;

    // random settings, coefficients mostly derived from their defaults
    for (int p = 0; p < 5; p++) begin
      write_all($urandom, 1'($urandom), 15'($urandom), 16'($urandom),
                rand_coef(mbvd_pkg::COEF_CUBIC_RST), rand_coef(mbvd_pkg::COEF_SQUARE_RST),
                rand_coef(mbvd_pkg::COEF_LINEAR_RST));
      push_random(190);
      wait_idle();
    end

    // bounded wait for stragglers, then the trailing quiet time
    for (k = 0; k < 20000 && expected_results.size() != 0; k++) @(negedge clk);
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never returned", longint'(expected_results.size()), 0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mbvd_pkg.sv
sv/mbvd_seq.sv
sv/mbvd_dp.sv
sv/motor_backemf_voltage_drive_top.sv
bench/motor_backemf_voltage_drive_top_tb.sv
